/* sv/yuvcm_pkg.sv */
// yuvcm_pkg: shared constants, codes and types of the yuv color matrix block
// no dependencies; imported by yuvcm_channel and yuv_color_matrix_pixel_pack
`timescale 1ns / 1ps
`default_nettype none

package yuvcm_pkg;

  // sample and component widths
  localparam int unsigned SAMPLE_W       = 8;
  localparam int unsigned COMP_W         = 10;
  localparam int unsigned WIDEN_SHIFT    = COMP_W - SAMPLE_W;
  localparam int unsigned FRAC_SHIFT     = 8;
  localparam int unsigned SHIFT_W        = 4;

  // coefficient width, default and upper bound
  localparam int unsigned COEFF_BITS_DEF = 20;
  localparam int unsigned COEFF_BITS_MAX = 20;

  // signed width that holds any post-offset channel value
  localparam int unsigned CLAMP_W        = COEFF_BITS_MAX + COMP_W + 4;

  // register file geometry
  localparam int unsigned REG_W          = 60;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned ADDR_W         = 6;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned CTL_W          = 5;
  localparam int unsigned LIM_W          = 2 * COMP_W;
  localparam int unsigned FMT_W          = 2;
  localparam int unsigned CTL_EN_BIT     = 4;

  // reset values
  localparam logic [LIM_W-1:0]  LIM_RESET   = LIM_W'(20'hFFC00);
  localparam logic [COMP_W-1:0] ALPHA_RESET = '1;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_OFS    = 3'd3,
    REG_CTL    = 3'd4,
    REG_LIM    = 3'd5,
    REG_ALPHA  = 3'd6,
    REG_FMT    = 3'd7
  } reg_idx_e;

  // output byte orders
  typedef enum logic [FMT_W-1:0] {
    FMT_ABGR = 2'd0,
    FMT_ARGB = 2'd1,
    FMT_YUV  = 2'd2
  } out_fmt_e;

  // per-stage advance strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_adv_t;

  // clamp to [lo, hi], the high limit wins when lo exceeds hi
  function automatic logic [COMP_W-1:0] clamp_comp(
    input logic signed [CLAMP_W-1:0] v,
    input logic [COMP_W-1:0]         lo,
    input logic [COMP_W-1:0]         hi
  );
    logic signed [CLAMP_W-1:0] r;
    logic signed [CLAMP_W-1:0] lo_s;
    logic signed [CLAMP_W-1:0] hi_s;
    lo_s = $signed({{(CLAMP_W - COMP_W){1'b0}}, lo});
    hi_s = $signed({{(CLAMP_W - COMP_W){1'b0}}, hi});
    r = v;
    if (r < lo_s) r = lo_s;
    if (r > hi_s) r = hi_s;
    return r[COMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/yuvcm_channel.sv */
// yuvcm_channel: one output channel of the color matrix, three pipeline stages
// depends on yuvcm_pkg (widths, pipe_adv_t, clamp_comp)
`timescale 1ns / 1ps
`default_nettype none

module yuvcm_channel import yuvcm_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire pipe_adv_t               adv_i,
  input  wire logic [COMP_W-1:0]       src_i [3],
  input  wire logic [3*COEFF_BITS-1:0] coeffs_i,
  input  wire logic [COEFF_BITS-1:0]   offset_i,
  input  wire logic [SHIFT_W-1:0]      shift_i,
  input  wire logic                    mtx_en_i,
  input  wire logic [COMP_W-1:0]       lo_i,
  input  wire logic [COMP_W-1:0]       hi_i,
  output logic [COMP_W-1:0]            comp_o
);

  localparam int unsigned PROD_W = COMP_W + 1 + COEFF_BITS;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned TOT_W  = ACC_W + 1;

  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] prod_q [3];
  logic [COMP_W-1:0]        bypass1_q;
  logic signed [ACC_W-1:0]  sum_w;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic [COMP_W-1:0]        bypass2_q;
  logic signed [TOT_W-1:0]  tot_w;
  logic signed [TOT_W-1:0]  tot_sh_w;
  logic [COMP_W-1:0]        comp_d;
  logic [COMP_W-1:0]        comp_q;

  // stage 1: coefficient products, component taken as non-negative
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = $signed({1'b0, src_i[k]}) * $signed(coeffs_i[k*COEFF_BITS +: COEFF_BITS]);
    end
  end

  // stage 2: sum of products, floor shift by the configured amount
  always_comb begin
    sum_w = $signed({{2{prod_q[0][PROD_W-1]}}, prod_q[0]})
          + $signed({{2{prod_q[1][PROD_W-1]}}, prod_q[1]})
          + $signed({{2{prod_q[2][PROD_W-1]}}, prod_q[2]});
    acc_d = sum_w >>> shift_i;
  end

  // stage 3: offset, fixed shift, clamp or pass-through
  always_comb begin
    tot_w    = $signed({acc_q[ACC_W-1], acc_q})
             + $signed({{(TOT_W - COEFF_BITS){offset_i[COEFF_BITS-1]}}, offset_i});
    tot_sh_w = tot_w >>> FRAC_SHIFT;
    if (mtx_en_i) begin
      comp_d = clamp_comp(CLAMP_W'(tot_sh_w), lo_i, hi_i);
    end else begin
      comp_d = bypass2_q;
    end
  end

  // payload registers, loaded as each stage advances
  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q    <= prod_d;
      bypass1_q <= src_i[0];
    end
    if (adv_i.s2) begin
      acc_q     <= acc_d;
      bypass2_q <= bypass1_q;
    end
    if (adv_i.s3) begin
      comp_q    <= comp_d;
    end
  end

  assign comp_o = comp_q;

endmodule

`default_nettype wire

/* sv/yuv_color_matrix_pixel_pack.sv */
// yuv_color_matrix_pixel_pack: top level, register file, pipeline control, byte pack
// depends on yuvcm_pkg and yuvcm_channel
`timescale 1ns / 1ps
`default_nettype none

// Converts one Y/U/V pixel per clock to four packed bytes while the output is not
// stalled. Each item passes four register stages (products, sum and shift, offset
// and clamp, byte pack), and a new item is taken every cycle in which the first
// stage can advance. Every stage advances when it is empty or when the stage after
// it moves, so empty slots close up and an item is accepted while a finished pixel
// still waits at the output. Registers sit on a 64-bit APB port at byte address
// 8*index and are meant to be written only while no pixel is in flight.
module yuv_color_matrix_pixel_pack import yuvcm_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // apb register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  // pixel input
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: [7:0] luma_sample, [15:8] chroma_u_sample, [23:16] chroma_v_sample
  input  wire logic [23:0]       s_axis_tdata,
  // packed result
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata: [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3
  output logic [31:0]            m_axis_tdata
);

  logic [REG_W-1:0]  row_q [3];
  logic [REG_W-1:0]  ofs_q;
  logic [CTL_W-1:0]  ctl_q;
  logic [LIM_W-1:0]  lim_q;
  logic [COMP_W-1:0] alpha_q;
  logic [FMT_W-1:0]  fmt_q;

  logic              wr_en;
  reg_idx_e          reg_idx;

  logic              v1_q, v2_q, v3_q, v4_q;
  logic              en1, en2, en3, en4;
  pipe_adv_t         adv;

  logic [COMP_W-1:0] src   [3];
  logic [COMP_W-1:0] ch_src [3][3];
  logic [COMP_W-1:0] comp  [3];
  logic [SHIFT_W-1:0] shift;
  logic              mtx_en;
  logic [COMP_W-1:0] lim_lo;
  logic [COMP_W-1:0] lim_hi;
  logic [COMP_W-1:0] alpha_d;
  logic [COMP_W-1:0] alpha3_q;
  logic [7:0]        b0, b1, b2, b3;
  logic [31:0]       tdata_d;
  logic [31:0]       tdata_q;

  // register decode
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1 -: IDX_W]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= '0;
      row_q[1] <= '0;
      row_q[2] <= '0;
      ofs_q    <= '0;
      ctl_q    <= '0;
      lim_q    <= LIM_RESET;
      alpha_q  <= ALPHA_RESET;
      fmt_q    <= FMT_ABGR;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW0:  row_q[0] <= pwdata[REG_W-1:0];
        REG_ROW1:  row_q[1] <= pwdata[REG_W-1:0];
        REG_ROW2:  row_q[2] <= pwdata[REG_W-1:0];
        REG_OFS:   ofs_q    <= pwdata[REG_W-1:0];
        REG_CTL:   ctl_q    <= pwdata[CTL_W-1:0];
        REG_LIM:   lim_q    <= pwdata[LIM_W-1:0];
        REG_ALPHA: alpha_q  <= pwdata[COMP_W-1:0];
        REG_FMT:   fmt_q    <= pwdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_idx)
      REG_ROW0:  prdata = DATA_W'(row_q[0]);
      REG_ROW1:  prdata = DATA_W'(row_q[1]);
      REG_ROW2:  prdata = DATA_W'(row_q[2]);
      REG_OFS:   prdata = DATA_W'(ofs_q);
      REG_CTL:   prdata = DATA_W'(ctl_q);
      REG_LIM:   prdata = DATA_W'(lim_q);
      REG_ALPHA: prdata = DATA_W'(alpha_q);
      REG_FMT:   prdata = DATA_W'(fmt_q);
      default:   prdata = '0;
    endcase
  end

  // stage advance: a stage moves when empty or when the next one moves
  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign adv = '{s1: en1, s2: en2, s3: en3};
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // widen samples to components
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      src[k] = {s_axis_tdata[k*SAMPLE_W +: SAMPLE_W], WIDEN_SHIFT'(0)};
    end
  end

  assign shift  = ctl_q[SHIFT_W-1:0];
  assign mtx_en = ctl_q[CTL_EN_BIT];
  assign lim_lo = lim_q[COMP_W-1:0];
  assign lim_hi = lim_q[LIM_W-1:COMP_W];

  // reorder a coefficient row to match the rotated component order
  function automatic logic [3*COEFF_BITS-1:0] rotate_coeffs(
    input logic [3*COEFF_BITS-1:0] row,
    input int unsigned             rot
  );
    logic [3*COEFF_BITS-1:0] r;
    int unsigned             sel;
    for (int j = 0; j < 3; j++) begin
      sel = j + rot;
      if (sel >= 3) sel = sel - 3;
      r[j*COEFF_BITS +: COEFF_BITS] = row[sel*COEFF_BITS +: COEFF_BITS];
    end
    return r;
  endfunction

  // three channel pipelines; each sees its own pass-through component first
  for (genvar c = 0; c < 3; c++) begin : g_ch
    assign ch_src[c][0] = src[c];
    assign ch_src[c][1] = src[(c + 1) % 3];
    assign ch_src[c][2] = src[(c + 2) % 3];

    yuvcm_channel #(
      .COEFF_BITS (COEFF_BITS)
    ) u_channel (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .src_i    (ch_src[c]),
      .coeffs_i (rotate_coeffs(row_q[c][3*COEFF_BITS-1:0], c)),
      .offset_i (ofs_q[c*COEFF_BITS +: COEFF_BITS]),
      .shift_i  (shift),
      .mtx_en_i (mtx_en),
      .lo_i     (lim_lo),
      .hi_i     (lim_hi),
      .comp_o   (comp[c])
    );
  end

  // alpha clamp lines up with stage 3
  assign alpha_d = mtx_en ? clamp_comp(CLAMP_W'(alpha_q), lim_lo, lim_hi) : alpha_q;

  always_ff @(posedge clk_i) begin
    if (en3) alpha3_q <= alpha_d;
  end

  // stage 4: byte pack in the selected order
  assign b0 = comp[0][COMP_W-1 -: 8];
  assign b1 = comp[1][COMP_W-1 -: 8];
  assign b2 = comp[2][COMP_W-1 -: 8];
  assign b3 = alpha3_q[COMP_W-1 -: 8];

  always_comb begin
    case (fmt_q)
      FMT_ARGB: tdata_d = {b3, b0, b1, b2};
      FMT_YUV:  tdata_d = {8'h00, b2, b1, b0};
      default:  tdata_d = {b3, b2, b1, b0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) tdata_q <= tdata_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = tdata_q;

  // a moving stage hands its item to the next one
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> v3_q)
    else $error("item lost between stage 2 and stage 3");

  // a blocked stage keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en4) |=> v3_q)
    else $error("stalled item dropped at stage 3");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
